// ----- sv/apf_pkg.sv -----
package apf_pkg;

   localparam int MAX_PAYLOAD_DEFAULT = 60;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0]  SRC_ADDR_RESET = 8'hFF;
   localparam logic [7:0]  HDR_LEN_BASE   = 8'd7;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_REFL  = 16'h8408;
   localparam logic [5:0]  SYM_PREAMBLE   = 6'h2A;
   localparam logic [5:0]  SYM_START_A    = 6'h38;
   localparam logic [5:0]  SYM_START_B    = 6'h2C;
   localparam logic [5:0]  SYM_END        = 6'h00;

   // one queued transaction for the symbol sequencer
   typedef struct packed {
      logic       rej;
      logic       hdr;
      logic       has_data;
      logic       last;
      logic [7:0] data;
      logic [7:0] dest;
      logic [7:0] len;
   } apf_cmd_type;

   typedef struct packed {
      logic        valid;
      apf_cmd_type cmd;
   } apf_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } apf_qstat_type;

   function automatic logic [5:0] sym_4b6b(input logic [3:0] nib);
      logic [5:0] s;
      case (nib)
         4'h0: s = 6'h0D;
         4'h1: s = 6'h0E;
         4'h2: s = 6'h13;
         4'h3: s = 6'h15;
         4'h4: s = 6'h16;
         4'h5: s = 6'h19;
         4'h6: s = 6'h1A;
         4'h7: s = 6'h1C;
         4'h8: s = 6'h23;
         4'h9: s = 6'h25;
         4'hA: s = 6'h26;
         4'hB: s = 6'h29;
         4'hC: s = 6'h2A;
         4'hD: s = 6'h2C;
         4'hE: s = 6'h32;
         4'hF: s = 6'h34;
         default: s = 6'h0D;
      endcase
      return s;
   endfunction

   function automatic logic [5:0] lead_sym(input logic [2:0] idx);
      logic [5:0] s;
      case (idx)
         3'd6: s = SYM_START_A;
         3'd7: s = SYM_START_B;
         default: s = SYM_PREAMBLE;
      endcase
      return s;
   endfunction

   // reflected crc-16, one byte
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- sv/apf_if.sv -----
interface apf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [7:0] dest_address;
   logic [7:0] payload_length;
   logic       first_of_message;
   logic       last_of_message;
   logic       empty_message;

   modport source (output valid, data_byte, dest_address, payload_length,
                   first_of_message, last_of_message, empty_message, input ready);
   modport sink   (input valid, data_byte, dest_address, payload_length,
                   first_of_message, last_of_message, empty_message, output ready);
endinterface

interface apf_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] line_symbol;
   logic       end_of_packet;
   logic       rejected;

   modport source (output valid, line_symbol, end_of_packet, rejected, input ready);
   modport sink   (input valid, line_symbol, end_of_packet, rejected, output ready);
endinterface

// ----- sv/apf_front.sv -----
module apf_front #(
   parameter int MAX_PAYLOAD = apf_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   apf_req_if.sink                req,
   input  apf_pkg::apf_qstat_type qstat,
   output apf_pkg::apf_push_type  push
);
   import apf_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   logic       in_packet_ff, in_packet_in;
   logic       dropping_ff, dropping_in;
   logic       accept;
   logic       first_e, last_e;
   logic [7:0] plen_e;
   logic       too_long;

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;

   assign first_e  = req.first_of_message || req.empty_message;
   assign last_e   = req.last_of_message || req.empty_message;
   assign plen_e   = req.empty_message ? 8'd0 : req.payload_length;
   assign too_long = plen_e > MAX_LEN;

   always_comb begin
      in_packet_in      = in_packet_ff;
      dropping_in       = dropping_ff;
      push.valid        = 1'b0;
      push.cmd.rej      = 1'b0;
      push.cmd.hdr      = 1'b0;
      push.cmd.has_data = !req.empty_message;
      push.cmd.last     = last_e;
      push.cmd.data     = req.data_byte;
      push.cmd.dest     = req.dest_address;
      push.cmd.len      = plen_e + HDR_LEN_BASE;
      if (accept) begin
         if (first_e) begin
            push.valid = 1'b1;
            if (too_long) begin
               push.cmd.rej  = 1'b1;
               in_packet_in  = 1'b0;
               dropping_in   = !last_e;
            end else begin
               push.cmd.hdr  = 1'b1;
               in_packet_in  = !last_e;
               dropping_in   = 1'b0;
            end
         end else if (dropping_ff) begin
            if (last_e) begin
               dropping_in = 1'b0;
            end
         end else if (in_packet_ff) begin
            push.valid = 1'b1;
            if (last_e) begin
               in_packet_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_packet_ff <= 1'b0;
         dropping_ff  <= 1'b0;
      end else begin
         in_packet_ff <= in_packet_in;
         dropping_ff  <= dropping_in;
      end
   end

endmodule

// ----- sv/apf_queue.sv -----
module apf_queue #(
   parameter int DEPTH = apf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  apf_pkg::apf_push_type  push,
   input  logic                   pop,
   output apf_pkg::apf_cmd_type   head,
   output apf_pkg::apf_qstat_type qstat
);
   import apf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   apf_cmd_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign qstat.full  = count_ff == FULL_CNT;
   assign qstat.empty = count_ff == '0;
   assign head        = mem_ff[rd_ptr_ff];

   assign do_push = push.valid && !qstat.full;
   assign do_pop  = pop && !qstat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/apf_back.sv -----
module apf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             source_address,
   input  apf_pkg::apf_cmd_type   head,
   input  apf_pkg::apf_qstat_type qstat,
   output logic                   pop,
   apf_rsp_if.source              rsp
);
   import apf_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_REJ  = 7'b0000010,
      ST_LEAD = 7'b0000100,
      ST_HDR  = 7'b0001000,
      ST_DATA = 7'b0010000,
      ST_CRC  = 7'b0100000,
      ST_EOP  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   apf_cmd_type cmd_ff, cmd_in;
   logic [15:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [5:0]  out_sym_ff, out_sym_in;
   logic        out_eop_ff, out_eop_in;
   logic        out_rej_ff, out_rej_in;

   logic        adv;
   logic        done;
   logic [7:0]  hdr_byte;
   logic [15:0] crc_inv;
   logic [7:0]  cur_byte;
   logic [5:0]  nib_sym;

   assign adv = !out_valid_ff || rsp.ready;

   always_comb begin
      case (cnt_ff[3:1])
         3'd0: hdr_byte = cmd_ff.len;
         3'd1: hdr_byte = cmd_ff.dest;
         3'd2: hdr_byte = source_address;
         default: hdr_byte = 8'h00;
      endcase
   end

   assign crc_inv = ~crc_ff;

   always_comb begin
      case (state_ff)
         ST_HDR:  cur_byte = hdr_byte;
         ST_DATA: cur_byte = cmd_ff.data;
         ST_CRC:  cur_byte = cnt_ff[1] ? crc_inv[15:8] : crc_inv[7:0];
         default: cur_byte = 8'h00;
      endcase
   end

   assign nib_sym = sym_4b6b(cnt_ff[0] ? cur_byte[3:0] : cur_byte[7:4]);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_sym_in   = out_sym_ff;
      out_eop_in   = out_eop_ff;
      out_rej_in   = out_rej_ff;
      pop          = 1'b0;
      done         = 1'b0;
      if (adv) begin
         case (state_ff)
            ST_IDLE: begin
               done = 1'b1;
            end
            ST_REJ: begin
               out_valid_in = 1'b1;
               out_sym_in   = SYM_END;
               out_eop_in   = 1'b0;
               out_rej_in   = 1'b1;
               done         = 1'b1;
            end
            ST_LEAD: begin
               out_valid_in = 1'b1;
               out_sym_in   = lead_sym(cnt_ff[2:0]);
               out_eop_in   = 1'b0;
               out_rej_in   = 1'b0;
               if (cnt_ff == 4'd7) begin
                  state_in = ST_HDR;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ST_HDR, ST_DATA: begin
               out_valid_in = 1'b1;
               out_sym_in   = nib_sym;
               out_eop_in   = 1'b0;
               out_rej_in   = 1'b0;
               if (!cnt_ff[0]) begin
                  crc_in = crc_fold(crc_ff, cur_byte);
               end
               if ((state_ff == ST_HDR && cnt_ff == 4'd9) ||
                   (state_ff == ST_DATA && cnt_ff == 4'd1)) begin
                  cnt_in = '0;
                  if (state_ff == ST_HDR && cmd_ff.has_data) begin
                     state_in = ST_DATA;
                  end else if (cmd_ff.last) begin
                     state_in = ST_CRC;
                  end else begin
                     done = 1'b1;
                  end
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ST_CRC: begin
               out_valid_in = 1'b1;
               out_sym_in   = nib_sym;
               out_eop_in   = 1'b0;
               out_rej_in   = 1'b0;
               if (cnt_ff == 4'd3) begin
                  state_in = ST_EOP;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ST_EOP: begin
               out_valid_in = 1'b1;
               out_sym_in   = SYM_END;
               out_eop_in   = 1'b1;
               out_rej_in   = 1'b0;
               crc_in       = CRC_INIT;
               done         = 1'b1;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
         if (done) begin
            // chain straight into the next queued transaction
            if (!qstat.empty) begin
               pop    = 1'b1;
               cmd_in = head;
               cnt_in = '0;
               if (head.rej) begin
                  state_in = ST_REJ;
                  crc_in   = CRC_INIT;
               end else if (head.hdr) begin
                  state_in = ST_LEAD;
                  crc_in   = CRC_INIT;
               end else begin
                  state_in = ST_DATA;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         crc_ff       <= CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      out_sym_ff <= out_sym_in;
      out_eop_ff <= out_eop_in;
      out_rej_ff <= out_rej_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.line_symbol   = out_sym_ff;
   assign rsp.end_of_packet = out_eop_ff;
   assign rsp.rejected      = out_rej_ff;

endmodule

// ----- sv/ask_packet_framer_4b6b.sv -----
// channel   dir  handshake            payload
// req_ch    in   valid / ready        data_byte, dest_address, payload_length,
//                                     first_of_message, last_of_message, empty_message
// rsp_ch    out  valid / ready        line_symbol, end_of_packet, rejected
// csr_*     in   csr_valid/csr_ready  csr_source_address
//
// one symbol per cycle out of the sequencer unless rsp stalls; a payload byte takes
// 2 symbols, a first transaction 18 (plus 2 with data), a last adds 5, a rejection 1
// a transaction is taken whenever the command queue has room, even while rsp stalls
// a stalled rsp holds the sequencer; the queue decouples req from rsp
// synchronous active-high reset; source address resets to 0xff
module ask_packet_framer_4b6b #(
   parameter int MAX_PAYLOAD = apf_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int QUEUE_DEPTH = apf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   apf_req_if.sink    req_ch,
   apf_rsp_if.source  rsp_ch,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_source_address
);
   import apf_pkg::*;

   logic [7:0]    src_addr_ff;
   apf_push_type  push;
   apf_qstat_type qstat;
   apf_cmd_type   head;
   logic          pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_addr_ff <= SRC_ADDR_RESET;
      end else if (csr_valid && csr_ready) begin
         src_addr_ff <= csr_source_address;
      end
   end

   apf_front #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .qstat (qstat),
      .push  (push)
   );

   apf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   apf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .source_address (src_addr_ff),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .rsp            (rsp_ch)
   );

endmodule

// ----- sv/apf_checker.sv -----
module apf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [5:0] rsp_line_symbol,
   input logic       rsp_end_of_packet,
   input logic       rsp_rejected
);

   // rejection carries no symbol and no end mark
   a_rej_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_line_symbol == 6'h00 && !rsp_end_of_packet)
      else $error("rejection with symbol or end mark");

   // end mark only on the zero symbol
   a_eop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_packet |-> rsp_line_symbol == 6'h00 && !rsp_rejected)
      else $error("end mark on nonzero symbol");

   // framed symbols are never zero
   a_sym_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rejected && !rsp_end_of_packet |-> rsp_line_symbol != 6'h00)
      else $error("zero symbol inside packet");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_symbol)
         && $stable(rsp_end_of_packet) && $stable(rsp_rejected))
      else $error("stalled result changed");

   // nothing offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ask_packet_framer_4b6b apf_checker u_apf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_line_symbol   (rsp_ch.line_symbol),
   .rsp_end_of_packet (rsp_ch.end_of_packet),
   .rsp_rejected      (rsp_ch.rejected)
);
